// ----- rtl/hs5_pkg.sv -----
`default_nettype none
package hs5_pkg;

  localparam int ValW    = 32;
  localparam int SumW    = 35;
  localparam int RowW    = 16;
  localparam int ColW    = 10;
  localparam int CfgWW   = 11;
  localparam int CfgHW   = 16;
  localparam int ApbAW   = 3;
  localparam int ApbDW   = 32;
  localparam int QDepth  = 4;
  localparam int QCntW   = $clog2(QDepth + 1);

  localparam int DefMaxWidth = 1024;
  localparam logic [CfgWW-1:0] RstWidth  = 11'd1024;
  localparam logic [CfgHW-1:0] RstHeight = 16'd1024;

  // register indexes, taken from paddr[2]
  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } hs5_reg_e;

  // one classified point, as queued between front and back
  typedef struct packed {
    logic [RowW-1:0]        row;
    logic [ColW-1:0]        col;
    logic                   has_a;
    logic                   has_b;
    logic                   border;
    logic                   last;
    logic signed [ValW-1:0] x;
    logic signed [ValW-1:0] up;
    logic signed [ValW-1:0] north;
    logic signed [ValW-1:0] left;
    logic signed [ValW-1:0] east;
  } hs5_op_t;

endpackage
`default_nettype wire

// ----- rtl/hs5_ram.sv -----
`default_nettype none
module hs5_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/hs5_fifo.sv -----
`default_nettype none
module hs5_fifo import hs5_pkg::*; (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire hs5_op_t        data_i,
  input  wire logic           pop_i,
  output hs5_op_t             data_o,
  output logic                valid_o,
  output logic [QCntW-1:0]    count_o
);

  localparam int PtrW = $clog2(QDepth);

  hs5_op_t          mem_q [QDepth];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             do_pop;

  assign do_pop  = pop_i && (cnt_q != '0);
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign count_o = cnt_q;

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + QCntW'(push_i) - QCntW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/hs5_front.sv -----
`default_nettype none
module hs5_front import hs5_pkg::*; #(
  parameter int MAX_WIDTH = DefMaxWidth
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   push_i,
  input  wire logic signed [ValW-1:0] point_value_i,
  output logic                        full_o,
  input  wire logic                   cfg_clr_i,
  input  wire logic [CfgWW-1:0]       grid_width_i,
  input  wire logic [CfgHW-1:0]       grid_height_i,
  input  wire logic [QCntW-1:0]       q_count_i,
  output logic                        q_push_o,
  output hs5_op_t                     q_data_o
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam logic [16:0] MaxW = 17'(MAX_WIDTH);

  logic [CW-1:0]         col_q, col_d, col_nxt, last_col;
  logic [RowW-1:0]       row_q, row_d, row_nxt, last_row;
  logic [16:0]           w_ext, w_eff;
  logic                  accept;
  logic                  end_of_row;
  logic [ValW-1:0]       prev_rd, old_rd;
  logic signed [ValW-1:0] left_q;
  logic                  s1_valid_q, s1_valid_d;
  hs5_op_t               s1_q, s1_d;

  assign w_ext = 17'(grid_width_i);
  always_comb begin
    if (w_ext < 17'd3) begin
      w_eff = 17'd3;
    end else if (w_ext > MaxW) begin
      w_eff = MaxW;
    end else begin
      w_eff = w_ext;
    end
  end
  assign last_col = CW'(w_eff - 17'd1);
  assign last_row = (grid_height_i < 16'd3) ? 16'd2 : grid_height_i - 16'd1;

  // one slot must stay free for the point held in stage 1
  assign full_o = (q_count_i + QCntW'(s1_valid_q)) >= QCntW'(QDepth);
  assign accept = push_i && !full_o;

  assign end_of_row = (col_q == last_col);
  assign col_nxt    = end_of_row ? '0 : col_q + 1'b1;
  assign row_nxt    = end_of_row ? ((row_q == last_row) ? '0 : row_q + 1'b1) : row_q;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_clr_i) begin
      col_d = '0;
      row_d = '0;
    end else if (accept) begin
      col_d = col_nxt;
      row_d = row_nxt;
    end
  end

  // line stores read one column ahead: the data is east for this point
  // and up for the next one
  hs5_ram #(.WIDTH(ValW), .DEPTH(MAX_WIDTH)) u_prev_row (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (col_q),
    .wdata_i (point_value_i),
    .re_i    (accept),
    .raddr_i (col_nxt),
    .rdata_o (prev_rd)
  );

  hs5_ram #(.WIDTH(ValW), .DEPTH(MAX_WIDTH)) u_old_row (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (col_q),
    .wdata_i (prev_rd),
    .re_i    (accept),
    .raddr_i (col_nxt),
    .rdata_o (old_rd)
  );

  always_comb begin
    s1_d        = s1_q;
    s1_d.row    = row_q;
    s1_d.col    = ColW'(col_q);
    s1_d.has_a  = (row_q != '0);
    s1_d.has_b  = (row_q == last_row);
    s1_d.border = (row_q == 16'd1) || (col_q == '0) || end_of_row;
    s1_d.last   = end_of_row;
    s1_d.x      = point_value_i;
    s1_d.up     = prev_rd;
    s1_d.north  = old_rd;
    s1_d.left   = left_q;
    s1_d.east   = '0;
    s1_valid_d  = accept && (s1_d.has_a || s1_d.has_b);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      left_q     <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      s1_valid_q <= s1_valid_d;
      if (accept) begin
        left_q <= prev_rd;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= s1_d;
    end
  end

  always_comb begin
    q_data_o      = s1_q;
    q_data_o.east = prev_rd;
  end
  assign q_push_o = s1_valid_q;

endmodule
`default_nettype wire

// ----- rtl/hs5_back.sv -----
`default_nettype none
module hs5_back import hs5_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire hs5_op_t                head_i,
  input  wire logic                   head_valid_i,
  output logic                        deq_o,
  output logic                        empty,
  input  wire logic                   pop,
  output logic [RowW-1:0]             out_row_o,
  output logic [ColW-1:0]             out_column_o,
  output logic signed [ValW-1:0]      new_value_o,
  output logic                        frame_last_o
);

  logic                   out_valid_q, out_valid_d;
  logic                   second_q, second_d;
  logic                   load;
  logic                   emit_a;
  logic signed [SumW-1:0] sum;
  logic signed [ValW-1:0] val_a;

  assign sum = (SumW'(head_i.up) <<< 2) + SumW'(head_i.north) + SumW'(head_i.x)
             + SumW'(head_i.left) + SumW'(head_i.east);
  // floor of sum / 8 always fits back into the value width
  assign val_a = head_i.border ? head_i.up : sum[SumW-1:3];

  assign load   = head_valid_i && (!out_valid_q || pop);
  assign emit_a = head_i.has_a && !second_q;

  always_comb begin
    out_valid_d = out_valid_q;
    second_d    = second_q;
    deq_o       = 1'b0;
    if (pop) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      out_valid_d = 1'b1;
      if (emit_a && head_i.has_b) begin
        second_d = 1'b1;
      end else begin
        second_d = 1'b0;
        deq_o    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      second_q    <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      second_q    <= second_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_column_o <= head_i.col;
      if (emit_a) begin
        out_row_o    <= head_i.row - 1'b1;
        new_value_o  <= val_a;
        frame_last_o <= 1'b0;
      end else begin
        out_row_o    <= head_i.row;
        new_value_o  <= head_i.x;
        frame_last_o <= head_i.last;
      end
    end
  end

  assign empty = !out_valid_q;

endmodule
`default_nettype wire

// ----- rtl/heat_stencil_5pt_2d.sv -----
// Five-point heat stencil, one explicit sweep over a raster-order grid.
// Input: push/full queue port, one signed Q15.16 point_value_i per beat,
// row by row. Output: empty/pop queue port; each beat carries the row and
// column of an updated point, its new value and frame_last_o on the final
// point of the grid. Row 0 gives no beat; rows 1..h-1 give the row above,
// and the last row also gives its own points, so 0, 1 or 2 beats per input.
// Throughput: one point per cycle unless full; the single output register
// paces the last row. Results pass stage 1, the queue and the output
// register. Two line stores of MAX_WIDTH words, each with one write port
// and one registered read port, hold the rows above and are read one
// column ahead. Grid size comes from the APB registers grid_width (0x0)
// and grid_height (0x4); a write restarts at row 0, column 0. The user
// must write only while idle; the block does not enforce it. Reset clears
// counters and queues, sets both sizes to 1024; the line stores need no
// clearing. When the receiver stalls, results back up into a four-entry
// queue and then full is raised; nothing is dropped.
`default_nettype none
module heat_stencil_5pt_2d import hs5_pkg::*; #(
  parameter int MAX_WIDTH = DefMaxWidth
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   push,
  output logic                        full,
  input  wire logic signed [ValW-1:0] point_value_i,
  output logic                        empty,
  input  wire logic                   pop,
  output logic [RowW-1:0]             out_row_o,
  output logic [ColW-1:0]             out_column_o,
  output logic signed [ValW-1:0]      new_value_o,
  output logic                        frame_last_o,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [ApbAW-1:0]       paddr,
  input  wire logic [ApbDW-1:0]       pwdata,
  output logic [ApbDW-1:0]            prdata,
  output logic                        pready
);

  logic [CfgWW-1:0] width_q, width_d;
  logic [CfgHW-1:0] height_q, height_d;
  logic             cfg_wr;
  hs5_reg_e         reg_sel;
  logic             q_push, q_deq, q_valid;
  logic [QCntW-1:0] q_count;
  hs5_op_t          q_in, q_head;

  assign pready  = 1'b1;
  assign reg_sel = hs5_reg_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_wr) begin
      case (reg_sel)
        REG_WIDTH:  width_d  = pwdata[CfgWW-1:0];
        REG_HEIGHT: height_d = pwdata[CfgHW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_WIDTH:  prdata = ApbDW'(width_q);
      REG_HEIGHT: prdata = ApbDW'(height_q);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RstWidth;
      height_q <= RstHeight;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  hs5_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .point_value_i (point_value_i),
    .full_o        (full),
    .cfg_clr_i     (cfg_wr),
    .grid_width_i  (width_q),
    .grid_height_i (height_q),
    .q_count_i     (q_count),
    .q_push_o      (q_push),
    .q_data_o      (q_in)
  );

  hs5_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .pop_i   (q_deq),
    .data_o  (q_head),
    .valid_o (q_valid),
    .count_o (q_count)
  );

  hs5_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (q_head),
    .head_valid_i (q_valid),
    .deq_o        (q_deq),
    .empty        (empty),
    .pop          (pop),
    .out_row_o    (out_row_o),
    .out_column_o (out_column_o),
    .new_value_o  (new_value_o),
    .frame_last_o (frame_last_o)
  );

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
module tb_top;
  import hs5_pkg::*;

  localparam int MaxW         = DefMaxWidth;
  localparam int CycleLimit   = 1_000_000;
  localparam int SettleCycles = 8;
  localparam int ExtremePts   = 64;
  localparam int PhasePts     = 150;

  typedef logic signed [ValW-1:0] val_t;

  // one result beat as seen on the output side
  typedef struct packed {
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
    val_t            value;
    logic            last;
  } beat_t;

  typedef struct {
    val_t  value;
    int    n_typed;   // -1: take the expected beats from the predictor
    beat_t t0;
    beat_t t1;
  } dir_step_t;

  localparam val_t VMax = val_t'(32'h7FFF_FFFF);
  localparam val_t VMin = val_t'(32'h8000_0000);

  logic clk_i = 1'b0;
  logic rst_ni;
  logic push, full, empty, pop;
  val_t point_value;
  logic [RowW-1:0] out_row;
  logic [ColW-1:0] out_column;
  val_t new_value;
  logic frame_last;
  logic psel, penable, pwrite, pready;
  logic [ApbAW-1:0] paddr;
  logic [ApbDW-1:0] pwdata, prdata;

  // predictor state
  val_t line_above [MaxW];
  val_t line_older [MaxW];
  val_t left_val;
  logic [ColW-1:0] col_pos;
  logic [RowW-1:0] row_pos;
  logic [CfgWW-1:0] cfg_width;
  logic [CfgHW-1:0] cfg_height;

  beat_t pending_beats[$];
  dir_step_t dir_steps[$];

  int send_idle_pct, recv_stall_pct, hold_req, hold_left;
  int mismatches, points_sent, results_seen, size_settings, cycle_count;

  heat_stencil_5pt_2d DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .point_value_i (point_value),
    .empty         (empty),
    .pop           (pop),
    .out_row_o     (out_row),
    .out_column_o  (out_column),
    .new_value_o   (new_value),
    .frame_last_o  (frame_last),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic flag_error(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endtask

  function automatic int eff_width();
    int w;
    w = cfg_width;
    if (w < 3) w = 3;
    if (w > MaxW) w = MaxW;
    return w;
  endfunction

  function automatic int eff_height();
    return (cfg_height < 3) ? 3 : int'(cfg_height);
  endfunction

  function automatic beat_t mk_beat(input int r, input int c, input val_t v, input bit l);
    return '{row: RowW'(r), col: ColW'(c), value: v, last: l};
  endfunction

  // steps the grid by one point, returns how many beats it causes
  function automatic int advance_grid(input val_t x, output beat_t b0, output beat_t b1);
    int w, h, c, r, n;
    val_t up, v;
    logic signed [SumW-1:0] acc;
    beat_t own;
    w = eff_width();
    h = eff_height();
    c = col_pos;
    r = row_pos;
    n = 0;
    b0 = '0;
    b1 = '0;
    up = line_above[c];
    if (r >= 1) begin
      if (r == 1 || c == 0 || c == w - 1) begin
        v = up;
      end else begin
        // 4u + north + south + west + east is exact in 35 bits; >>> 3 floors
        acc = (SumW'(up) <<< 2) + SumW'(line_older[c]) + SumW'(x) + SumW'(left_val)
            + SumW'(line_above[c + 1]);
        v = acc[SumW-1:3];
      end
      b0 = mk_beat(r - 1, c, v, 1'b0);
      n = 1;
    end
    if (r == h - 1) begin
      own = mk_beat(r, c, x, c == w - 1);
      if (n == 0) b0 = own;
      else b1 = own;
      n++;
    end
    left_val = up;
    line_older[c] = up;
    line_above[c] = x;
    if (c + 1 >= w) begin
      c = 0;
      r = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      c++;
    end
    col_pos = ColW'(c);
    row_pos = RowW'(r);
    return n;
  endfunction

  function automatic val_t rand_point();
    int pick;
    pick = $urandom_range(99);
    if (pick < 8) return pick[0] ? VMax : VMin;
    if (pick < 12) return pick[0] ? val_t'(-1) : val_t'(0);
    if (pick < 30) return val_t'($signed($urandom_range(4095)) - 2048);
    return val_t'($urandom);
  endfunction

  function automatic void add_dir(input val_t value, input int n,
                                  input beat_t t0 = '0, input beat_t t1 = '0);
    dir_step_t s;
    s.value = value;
    s.n_typed = n;
    s.t0 = t0;
    s.t1 = t1;
    dir_steps.push_back(s);
  endfunction

  task automatic push_point(input val_t value, input int n_typed = -1,
                            input beat_t t0 = '0, input beat_t t1 = '0);
    int n;
    beat_t b0, b1;
    @(negedge clk_i);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push <= 1'b1;
    point_value <= value;
    do @(posedge clk_i); while (full);
    n = advance_grid(value, b0, b1);
    if (n_typed >= 0) begin
      n = n_typed;
      b0 = t0;
      b1 = t1;
    end
    if (n > 0) pending_beats.push_back(b0);
    if (n > 1) pending_beats.push_back(b1);
    points_sent++;
  endtask

  task automatic wait_drain();
    @(negedge clk_i);
    push <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk_i);
  endtask

  // optional write, then read back and compare
  task automatic reg_access(input hs5_reg_e idx, input bit write_it, input int unsigned data);
    logic [ApbDW-1:0] want;
    want = (idx == REG_WIDTH) ? ApbDW'(data[CfgWW-1:0]) : ApbDW'(data[CfgHW-1:0]);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= write_it;
    paddr <= ApbAW'({idx, 2'b00});
    pwdata <= data;
    if (write_it) begin
      @(negedge clk_i);
      penable <= 1'b1;
      do @(posedge clk_i); while (!pready);
      if (idx == REG_WIDTH) cfg_width = data[CfgWW-1:0];
      else cfg_height = data[CfgHW-1:0];
      col_pos = '0;
      row_pos = '0;
      @(negedge clk_i);
      penable <= 1'b0;
      pwrite <= 1'b0;
    end
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== want)
      flag_error($sformatf("register %s read %0h, expected %0h", idx.name(), prdata, want));
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic resize(input int w, input int h, input bit do_w, input bit do_h);
    wait_drain();
    repeat (SettleCycles) @(posedge clk_i);
    if (do_w) reg_access(REG_WIDTH, 1'b1, w);
    if (do_h) reg_access(REG_HEIGHT, 1'b1, h);
    size_settings++;
  endtask

  task automatic random_run(output int count);
    int w, h, pick, full_grid;
    pick = $urandom_range(99);
    if (pick < 80) w = $urandom_range(3, 8);
    else if (pick < 92) w = $urandom_range(9, 40);
    else w = $urandom_range(0, 2);
    pick = $urandom_range(99);
    if (pick < 80) h = $urandom_range(3, 6);
    else if (pick < 90) h = $urandom_range(7, 12);
    else h = $urandom_range(0, 2);
    pick = $urandom_range(99);
    resize(w, h, pick < 85, pick < 70 || pick >= 85);
    full_grid = eff_width() * eff_height();
    pick = $urandom_range(99);
    // mostly whole grids, some cut short by the next size write
    if (pick < 70) count = full_grid * (1 + $urandom_range(1));
    else if (pick < 90) count = $urandom_range(1, full_grid - 1);
    else count = full_grid + $urandom_range(1, full_grid - 1);
    for (int i = 0; i < count; i++) begin
      push_point(rand_point());
      if ($urandom_range(249) == 0) wait_drain();
    end
  endtask

  // receiver side: random stalls plus one long hold-off when it is requested
  always @(negedge clk_i) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin : check_results
    beat_t got, want;
    if (rst_ni && pop && !empty) begin
      got = '{row: out_row, col: out_column, value: new_value, last: frame_last};
      results_seen++;
      if (pending_beats.size() == 0) begin
        flag_error($sformatf("unexpected beat row %0d col %0d value %0d last %0d",
                             got.row, got.col, got.value, got.last));
      end else begin
        want = pending_beats.pop_front();
        if (got.row !== want.row || got.col !== want.col ||
            got.value !== want.value || got.last !== want.last)
          flag_error($sformatf("row %0d/%0d col %0d/%0d value %0d/%0d last %0d/%0d",
                               want.row, got.row, want.col, got.col,
                               want.value, got.value, want.last, got.last));
      end
    end
  end

  initial begin
    int send_mix [4];
    int recv_mix [4];
    int run_len, phase_points;
    send_mix = '{0, 60, 0, 37};
    recv_mix = '{0, 0, 60, 37};
    rst_ni = 1'b0;
    push = 1'b0;
    point_value = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    hold_req = 0;
    hold_left = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    cfg_width = RstWidth;
    cfg_height = RstHeight;
    col_pos = '0;
    row_pos = '0;
    left_val = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    reg_access(REG_WIDTH, 1'b0, RstWidth);
    reg_access(REG_HEIGHT, 1'b0, RstHeight);

    // reset sizes: the first row gives nothing
    repeat (3) add_dir(VMax, 0);
    // checkerboard of extremes on a 3x3 grid (clamped sizes)
    add_dir(VMax, 0);
    add_dir(VMin, 0);
    add_dir(VMax, 0);
    add_dir(VMin, 1, mk_beat(0, 0, VMax, 0));
    add_dir(VMax, 1, mk_beat(0, 1, VMin, 0));
    add_dir(VMin, 1, mk_beat(0, 2, VMax, 0));
    add_dir(VMax, 2, mk_beat(1, 0, VMin, 0), mk_beat(2, 0, VMax, 0));
    add_dir(VMin, -1);
    add_dir(VMax, 2, mk_beat(1, 2, VMin, 0), mk_beat(2, 2, VMax, 1));
    // next grid follows without a size write; interior sum -12 floors to -2
    add_dir(0, -1);
    add_dir(-1, -1);
    add_dir(1, -1);
    add_dir(-1, -1);
    add_dir(-2, -1);
    add_dir(-1, -1);
    add_dir(1, -1);
    add_dir(-1, -1);
    add_dir(0, -1);

    foreach (dir_steps[i]) begin
      // size write lands mid-row, after the reset-size points
      if (i == 3) resize(1, 2, 1'b1, 1'b1);
      push_point(dir_steps[i].value, dir_steps[i].n_typed, dir_steps[i].t0, dir_steps[i].t1);
    end

    // receiver holds off while the sender keeps offering points
    resize(5, 4, 1'b1, 1'b1);
    @(posedge clk_i);
    hold_req = 300;
    repeat (40) push_point(rand_point());

    // widest setting (width clamped from above), then tallest, both cut short
    resize(2047, 3, 1'b1, 1'b1);
    repeat (ExtremePts) push_point(rand_point());
    resize(3, 65535, 1'b1, 1'b1);
    repeat (ExtremePts) push_point(rand_point());
    resize(4, 4, 1'b1, 1'b1);

    for (int ph = 0; ph < 4; ph++) begin
      wait_drain();
      send_idle_pct = send_mix[ph];
      recv_stall_pct = recv_mix[ph];
      phase_points = 0;
      while (phase_points < PhasePts) begin
        random_run(run_len);
        phase_points += run_len;
      end
    end

    wait_drain();
    recv_stall_pct = 0;
    repeat (SettleCycles) @(posedge clk_i);
    $display("run covered %0d points and %0d result beats over %0d grid sizes",
             points_sent, results_seen, size_settings);
    $display("size clamps, four idle mixes and one long hold-off; %0d mismatches",
             mismatches);
    if (mismatches == 0 && pending_beats.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
